[rtl/core/tirw_pkg.sv]
// shared types and constants for the tape image record walker
`default_nettype none
package tirw_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FMT_PAD32 = 2'd0,
    FMT_RAW32 = 2'd1,
    FMT_PAD16 = 2'd2
  } tirw_format_t;

  localparam logic [CFG_IDX_W-1:0] REG_TAPE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 2'd1;

  localparam logic [1:0]       FORMAT_RESET  = 2'd0;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd65536;

  localparam logic [WORD_W-1:0] EOT_WORD     = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] HDR_LONG     = 32'd4;
  localparam logic [WORD_W-1:0] HDR_SHORT    = 32'd2;
  localparam logic [WORD_W-1:0] FRAME_LONG   = 32'd8;
  localparam logic [WORD_W-1:0] FRAME_SHORT  = 32'd2;

  typedef enum logic [2:0] {
    EV_RECORD       = 3'd0,
    EV_TAPE_MARK    = 3'd1,
    EV_END_LOGICAL  = 3'd2,
    EV_END_PHYSICAL = 3'd3,
    EV_INVALID      = 3'd4,
    EV_FINISHED     = 3'd5
  } tirw_event_t;

  typedef struct packed {
    logic [WORD_W-1:0] length_word;
    logic              no_data;
  } tirw_item_t;

  typedef struct packed {
    tirw_event_t       event_kind;
    logic              error_marked;
    logic              starts_new_file;
    logic [WORD_W-1:0] object_position;
    logic [WORD_W-1:0] object_number;
    logic [WORD_W-1:0] record_number;
    logic [WORD_W-1:0] file_number;
    logic [LEN_W-1:0]  record_length;
    logic [WORD_W-1:0] next_position;
  } tirw_result_t;

endpackage
`default_nettype wire

[rtl/core/tirw_in_if.sv]
// input channel interface: header word transactions
`default_nettype none
interface tirw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] length_word;
  logic        no_data;

  modport source (output valid, output length_word, output no_data, input ready);
  modport sink   (input valid, input length_word, input no_data, output ready);
endinterface
`default_nettype wire

[rtl/core/tirw_out_if.sv]
// result channel interface: walk event transactions
`default_nettype none
interface tirw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic        error_marked;
  logic        starts_new_file;
  logic [31:0] object_position;
  logic [31:0] object_number;
  logic [31:0] record_number;
  logic [31:0] file_number;
  logic [30:0] record_length;
  logic [31:0] next_position;

  modport source (output valid, output event_kind, output error_marked,
                  output starts_new_file, output object_position, output object_number,
                  output record_number, output file_number, output record_length,
                  output next_position, input ready);
  modport sink   (input valid, input event_kind, input error_marked,
                  input starts_new_file, input object_position, input object_number,
                  input record_number, input file_number, input record_length,
                  input next_position, output ready);
endinterface
`default_nettype wire

[rtl/core/tirw_in_stage.sv]
// input register stage for header word transactions
`default_nettype none
module tirw_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tirw_in_if.sink            in_ch,
  input  wire logic          take,
  output logic               item_valid,
  output tirw_pkg::tirw_item_t item
);

  logic                 valid_r;
  logic                 valid_nxt;
  tirw_pkg::tirw_item_t item_r;
  logic                 rdy;

  assign rdy         = !valid_r || take;
  assign in_ch.ready = rdy;
  assign valid_nxt   = rdy ? in_ch.valid : valid_r;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && rdy) begin
      item_r.length_word <= in_ch.length_word;
      item_r.no_data     <= in_ch.no_data;
    end
  end

endmodule
`default_nettype wire

[rtl/core/tirw_walk.sv]
// walk state, configuration registers and per-header decode
`default_nettype none
module tirw_walk (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [tirw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tirw_pkg::LEN_W-1:0]          cfg_wdata,
  input  wire logic                                step,
  input  wire tirw_pkg::tirw_item_t                item,
  output tirw_pkg::tirw_result_t                   result
);

  logic [1:0]                     format_r;
  logic [tirw_pkg::LEN_W-1:0]     max_len_r;
  logic [tirw_pkg::WORD_W-1:0]    pos_r, pos_nxt;
  logic [tirw_pkg::WORD_W-1:0]    obj_r, obj_nxt;
  logic [tirw_pkg::WORD_W-1:0]    rec_r, rec_nxt;
  logic [tirw_pkg::WORD_W-1:0]    file_r, file_nxt;
  logic                           after_tm_r, after_tm_nxt;
  logic                           done_r, done_nxt;

  logic                           short_words;
  logic [tirw_pkg::WORD_W-1:0]    word;
  logic                           phys_end;
  logic                           err_bit;
  logic [tirw_pkg::LEN_W-1:0]     len;
  logic [tirw_pkg::WORD_W-1:0]    len_ext;
  logic [tirw_pkg::WORD_W-1:0]    len_even;
  logic [tirw_pkg::WORD_W-1:0]    hdr;
  logic [tirw_pkg::WORD_W-1:0]    frame;
  logic [tirw_pkg::WORD_W-1:0]    data_span;
  logic [tirw_pkg::WORD_W-1:0]    rec_next;
  tirw_pkg::tirw_event_t          kind;
  logic [tirw_pkg::WORD_W-1:0]    next_pos;

  assign short_words = (format_r == tirw_pkg::FMT_PAD16);
  assign word        = short_words ? {16'd0, item.length_word[15:0]} : item.length_word;
  assign phys_end    = item.no_data || (!short_words && (word == tirw_pkg::EOT_WORD));
  assign err_bit     = !short_words && word[tirw_pkg::WORD_W-1];
  assign len         = word[tirw_pkg::LEN_W-1:0];
  assign len_ext     = {1'b0, len};
  assign len_even    = (len_ext + 32'd1) & ~32'd1;
  assign hdr         = short_words ? tirw_pkg::HDR_SHORT : tirw_pkg::HDR_LONG;
  assign frame       = short_words ? tirw_pkg::FRAME_SHORT : tirw_pkg::FRAME_LONG;
  assign data_span   = (format_r == tirw_pkg::FMT_RAW32) ? len_ext : len_even;
  assign rec_next    = pos_r + frame + data_span;

  always_comb begin
    kind     = tirw_pkg::EV_RECORD;
    next_pos = pos_r;
    if (done_r) begin
      kind = tirw_pkg::EV_FINISHED;
    end else if (phys_end) begin
      kind = tirw_pkg::EV_END_PHYSICAL;
    end else if (len == '0) begin
      if (after_tm_r) begin
        kind = tirw_pkg::EV_END_LOGICAL;
      end else begin
        kind     = tirw_pkg::EV_TAPE_MARK;
        next_pos = pos_r + hdr;
      end
    end else if (len > max_len_r) begin
      kind = tirw_pkg::EV_INVALID;
    end else begin
      kind     = tirw_pkg::EV_RECORD;
      next_pos = rec_next;
    end
  end

  always_comb begin
    result.event_kind      = kind;
    result.error_marked    = !done_r && !phys_end && err_bit;
    result.starts_new_file = (kind == tirw_pkg::EV_RECORD) && after_tm_r;
    result.object_position = pos_r;
    result.object_number   = obj_r;
    result.record_number   = rec_r;
    result.file_number     = file_r;
    result.record_length   = (done_r || phys_end) ? '0 : len;
    result.next_position   = next_pos;
  end

  always_comb begin
    pos_nxt      = pos_r;
    obj_nxt      = obj_r;
    rec_nxt      = rec_r;
    file_nxt     = file_r;
    after_tm_nxt = after_tm_r;
    done_nxt     = done_r;
    if (step) begin
      case (kind)
        tirw_pkg::EV_TAPE_MARK: begin
          pos_nxt      = next_pos;
          obj_nxt      = obj_r + 32'd1;
          file_nxt     = file_r + 32'd1;
          rec_nxt      = 32'd1;
          after_tm_nxt = 1'b1;
        end
        tirw_pkg::EV_RECORD: begin
          pos_nxt      = next_pos;
          obj_nxt      = obj_r + 32'd1;
          rec_nxt      = rec_r + 32'd1;
          after_tm_nxt = 1'b0;
        end
        tirw_pkg::EV_END_LOGICAL,
        tirw_pkg::EV_END_PHYSICAL,
        tirw_pkg::EV_INVALID: begin
          done_nxt = 1'b1;
        end
        default: begin
          done_nxt = done_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r   <= tirw_pkg::FORMAT_RESET;
      max_len_r  <= tirw_pkg::MAX_LEN_RESET;
      pos_r      <= '0;
      obj_r      <= 32'd1;
      rec_r      <= 32'd1;
      file_r     <= 32'd1;
      after_tm_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      obj_r      <= obj_nxt;
      rec_r      <= rec_nxt;
      file_r     <= file_nxt;
      after_tm_r <= after_tm_nxt;
      done_r     <= done_nxt;
      if (cfg_we && (cfg_index == tirw_pkg::REG_TAPE_FORMAT)) begin
        format_r <= cfg_wdata[1:0];
      end
      if (cfg_we && (cfg_index == tirw_pkg::REG_MAX_LEN)) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/tirw_out_stage.sv]
// result register driving the event transaction channel
`default_nettype none
module tirw_out_stage (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   item_valid,
  input  wire tirw_pkg::tirw_result_t result,
  output logic                        take,
  tirw_out_if.source                  out_ch
);

  logic                   valid_r;
  logic                   valid_nxt;
  tirw_pkg::tirw_result_t data_r;

  assign take      = !valid_r || out_ch.ready;
  assign valid_nxt = take ? item_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && take) begin
      data_r <= result;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.event_kind      = data_r.event_kind;
  assign out_ch.error_marked    = data_r.error_marked;
  assign out_ch.starts_new_file = data_r.starts_new_file;
  assign out_ch.object_position = data_r.object_position;
  assign out_ch.object_number   = data_r.object_number;
  assign out_ch.record_number   = data_r.record_number;
  assign out_ch.file_number     = data_r.file_number;
  assign out_ch.record_length   = data_r.record_length;
  assign out_ch.next_position   = data_r.next_position;

endmodule
`default_nettype wire

[rtl/core/tape_image_record_walker.sv]
// top level of the tape image record walker
// Returns one event transaction for each header word transaction, via the input register
// and then the result register. The position add, length compare and count updates of
// the walk state sit between those two registers, so a new header can enter every cycle
// while the result channel keeps up; a stall on the result side holds both registers and
// drops in_ch.ready once the input register holds a header. Configuration writes
// (index 0 tape format, index 1 maximum record length) apply to headers reaching the walk
// stage after the write; the user must make them only while idle, which is not enforced.
`default_nettype none
module tape_image_record_walker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tirw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tirw_pkg::LEN_W-1:0]     cfg_wdata,
  tirw_in_if.sink                             in_ch,
  tirw_out_if.source                          out_ch
);

  logic                   item_valid;
  tirw_pkg::tirw_item_t   item;
  tirw_pkg::tirw_result_t result;
  logic                   take;
  logic                   step;

  assign step = item_valid && take;

  tirw_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tirw_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  tirw_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
